FILE: rtl/ssww_pkg.sv
// ----------------------------------------------------------------------------
// ssww_pkg
// Shared types, constants and character helpers for the whole-word search.
// ----------------------------------------------------------------------------
`default_nettype none

package ssww_pkg;

  // sizes
  localparam int unsigned MaxPattern  = 16;
  localparam int unsigned WinDepth    = MaxPattern + 2;
  localparam int unsigned CharBits    = 16;
  localparam int unsigned PosBits     = 20;
  localparam int unsigned CountBits   = PosBits + 1;
  localparam int unsigned LenBits     = $clog2(MaxPattern + 1);
  localparam int unsigned SlotBits    = $clog2(WinDepth);
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 64;
  localparam int unsigned ModeBits    = 3;
  localparam int unsigned PatWords    = 4;
  localparam int unsigned CharsPerWord = CfgDataBits / CharBits;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegMode     = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegPatLen   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegStartPos = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegPatWord0 = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegPatWord1 = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegPatWord2 = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegPatWord3 = 3'd6;

  // mode flag bit positions
  localparam int unsigned ModeMatchCase = 0;
  localparam int unsigned ModeWholeWord = 1;
  localparam int unsigned ModeReverse   = 2;

  typedef logic [CharBits-1:0]  char_t;
  typedef logic [PosBits-1:0]   pos_t;
  typedef logic [LenBits-1:0]   len_t;
  typedef logic [SlotBits-1:0]  slot_t;
  typedef char_t [WinDepth-1:0]   win_t;
  typedef char_t [MaxPattern-1:0] pat_t;

  // candidate alignment handed to the comparator
  typedef struct packed {
    len_t  len;
    slot_t top;
    logic  exact;
  } cand_ctrl_t;

  // ascii upper case to lower case, everything else untouched
  function automatic char_t fold(input char_t c);
    char_t r;
    r = c;
    if (c >= char_t'(16'h41) && c <= char_t'(16'h5a)) begin
      r = c + char_t'(16'h20);
    end
    return r;
  endfunction

  // ascii letter or digit
  function automatic logic is_word(input char_t c);
    return (c >= char_t'(16'h30) && c <= char_t'(16'h39)) ||
           (c >= char_t'(16'h41) && c <= char_t'(16'h5a)) ||
           (c >= char_t'(16'h61) && c <= char_t'(16'h7a));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ssww_if.sv
// ----------------------------------------------------------------------------
// ssww_if
// Valid/ready channels for text characters in and search results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssww_in_if
  import ssww_pkg::*;
;
  logic  valid;
  logic  ready;
  char_t text_char;
  logic  last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface ssww_out_if
  import ssww_pkg::*;
;
  logic valid;
  logic ready;
  logic found;
  pos_t match_position;

  modport source (output valid, output found, output match_position, input ready);
  modport sink   (input valid, input found, input match_position, output ready);
endinterface

`default_nettype wire

FILE: rtl/ssww_cand.sv
// ----------------------------------------------------------------------------
// ssww_cand
// Parallel compare of the pattern against the character window at one
// alignment: pattern character j sits at window slot top - j.
// ----------------------------------------------------------------------------
`default_nettype none

module ssww_cand
  import ssww_pkg::*;
(
  input  win_t       win_i,
  input  pat_t       pat_i,
  input  cand_ctrl_t ctrl_i,
  output logic       equal_o
);

  logic [MaxPattern-1:0] ok;

  // one comparator per pattern character, unused ones pass
  always_comb begin
    for (int j = 0; j < MaxPattern; j++) begin
      logic [SlotBits:0] slot;
      char_t             t;
      char_t             p;
      slot = {1'b0, ctrl_i.top} - (SlotBits + 1)'(j);
      t    = '0;
      if (slot < (SlotBits + 1)'(WinDepth)) begin
        t = win_i[slot[SlotBits-1:0]];
      end
      p = pat_i[j];
      if (!ctrl_i.exact) begin
        t = fold(t);
        p = fold(p);
      end
      ok[j] = ((LenBits + 1)'(j) >= {1'b0, ctrl_i.len}) || (t == p);
    end
  end

  assign equal_o = &ok;

endmodule

`default_nettype wire

FILE: rtl/substring_search_whole_word.sv
// ----------------------------------------------------------------------------
// substring_search_whole_word
// Streaming search of a configured pattern in a character stream.
// ----------------------------------------------------------------------------
// Takes one text character per clock with no gaps of its own: a character
// goes into an input register, and in the next cycle the whole window of the
// last 18 characters is compared against all pattern characters in parallel,
// so the rate is one character per cycle. The result for a text leaves
// through an output register, loaded as its last character leaves the
// input register; a waiting result only stalls the input when another
// last character arrives. There is no clearing pass after reset. Write
// the registers only while the block is idle.
`default_nettype none

module substring_search_whole_word
  import ssww_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  ssww_in_if.sink                     in_if,
  ssww_out_if.source                  out_if,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i
);

  // configuration registers
  logic [ModeBits-1:0]    mode_q;
  len_t                   pat_len_q;
  pos_t                   start_q;
  logic [CfgDataBits-1:0] pat_word_q [PatWords];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      pat_len_q <= len_t'(1);
      start_q   <= '0;
      for (int w = 0; w < PatWords; w++) begin
        pat_word_q[w] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegMode:     mode_q        <= cfg_data_i[ModeBits-1:0];
        RegPatLen:   pat_len_q     <= cfg_data_i[LenBits-1:0];
        RegStartPos: start_q       <= cfg_data_i[PosBits-1:0];
        RegPatWord0: pat_word_q[0] <= cfg_data_i;
        RegPatWord1: pat_word_q[1] <= cfg_data_i;
        RegPatWord2: pat_word_q[2] <= cfg_data_i;
        RegPatWord3: pat_word_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pattern characters out of the packed words
  pat_t pat;
  always_comb begin
    for (int k = 0; k < MaxPattern; k++) begin
      pat[k] = pat_word_q[k / CharsPerWord][(k % CharsPerWord) * CharBits +: CharBits];
    end
  end

  // input register and output register handshake
  logic  s0_valid_q;
  char_t s0_char_q;
  logic  s0_last_q;
  logic  out_valid_q;
  logic  found_q;
  pos_t  pos_q;
  logic  out_free;
  logic  s0_adv;

  assign out_free     = !out_valid_q || out_if.ready;
  assign s0_adv       = s0_valid_q && (!s0_last_q || out_free);
  assign in_if.ready  = !s0_valid_q || s0_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s0_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      s0_char_q <= in_if.text_char;
      s0_last_q <= in_if.last_char;
    end
  end

  // search state
  win_t                 win_q;
  logic [CountBits-1:0] count_q;
  logic                 have_q;
  pos_t                 best_q;

  // window with the new character shifted in
  win_t nw;
  always_comb begin
    nw[0] = s0_char_q;
    for (int k = 1; k < WinDepth; k++) begin
      nw[k] = win_q[k-1];
    end
  end

  // effective length and candidate bounds
  len_t                 len;
  logic                 len_zero;
  pos_t                 n;
  pos_t                 len_pos;
  logic                 in_range;
  logic [PosBits:0]     n_plus1;
  cand_ctrl_t           ctrl1;
  cand_ctrl_t           ctrl2;
  logic                 eq1;
  logic                 eq2;

  always_comb begin
    len      = (pat_len_q > len_t'(MaxPattern)) ? len_t'(MaxPattern) : pat_len_q;
    len_zero = (len == '0);
    n        = count_q[PosBits-1:0];
    len_pos  = pos_t'(len);
    in_range = !count_q[PosBits];
    n_plus1  = {1'b0, n} + (PosBits + 1)'(1);
    ctrl1.len   = len;
    ctrl1.top   = slot_t'(len);
    ctrl1.exact = mode_q[ModeMatchCase];
    ctrl2.len   = len;
    ctrl2.top   = slot_t'(len) - slot_t'(1);
    ctrl2.exact = mode_q[ModeMatchCase];
  end

  // candidate ending one before the new character
  ssww_cand u_cand_inner (
    .win_i   (nw),
    .pat_i   (pat),
    .ctrl_i  (ctrl1),
    .equal_o (eq1)
  );

  // candidate ending at the text end
  ssww_cand u_cand_end (
    .win_i   (nw),
    .pat_i   (pat),
    .ctrl_i  (ctrl2),
    .equal_o (eq2)
  );

  // qualification and best match update
  logic c1_ok, c2_ok, q1, q2;
  pos_t s1, s2;
  logic have_d;
  pos_t best_d;

  always_comb begin
    c1_ok = in_range && !len_zero && (n >= len_pos);
    c2_ok = in_range && !len_zero && s0_last_q && (n_plus1 >= {1'b0, len_pos});
    s1    = n - len_pos;
    s2    = n_plus1[PosBits-1:0] - len_pos;
    q1    = c1_ok && eq1;
    q2    = c2_ok && eq2;
    if (mode_q[ModeWholeWord]) begin
      if ((n > len_pos) && is_word(nw[slot_t'(len) + slot_t'(1)])) q1 = 1'b0;
      if (is_word(nw[0])) q1 = 1'b0;
      if ((n_plus1 > {1'b0, len_pos}) && is_word(nw[slot_t'(len)])) q2 = 1'b0;
    end
    have_d = have_q;
    best_d = best_q;
    if (mode_q[ModeReverse]) begin
      // latest match ending at or before the start position
      priority if (q2 && (n_plus1 <= {1'b0, start_q})) begin
        have_d = 1'b1;
        best_d = s2;
      end else if (q1 && (n <= start_q)) begin
        have_d = 1'b1;
        best_d = s1;
      end else begin
        have_d = have_q;
      end
    end else if (!have_q) begin
      // first match starting at or after the start position
      priority if (q1 && (s1 >= start_q)) begin
        have_d = 1'b1;
        best_d = s1;
      end else if (q2 && (s2 >= start_q)) begin
        have_d = 1'b1;
        best_d = s2;
      end else begin
        have_d = 1'b0;
      end
    end
  end

  // state update, cleared after the last character of a text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      count_q <= '0;
      have_q  <= 1'b0;
      best_q  <= '0;
    end else if (s0_adv) begin
      if (s0_last_q) begin
        win_q   <= '0;
        count_q <= '0;
        have_q  <= 1'b0;
        best_q  <= '0;
      end else begin
        win_q   <= nw;
        count_q <= in_range ? count_q + CountBits'(1) : count_q;
        have_q  <= have_d;
        best_q  <= best_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s0_adv && s0_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_adv && s0_last_q) begin
      found_q <= have_d;
      pos_q   <= have_d ? best_d : '0;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.found          = found_q;
  assign out_if.match_position = pos_q;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming whole-word substring search.
// A short hand-written plan covers reset values, field extremes, every mode
// bit, zero and oversized pattern lengths, short texts and start positions
// past the end of the text. Random settings and texts follow, most of them
// seeded with full or partial pattern copies in mixed case. Every result
// beat is compared with its planned value or a cycle-free model in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssww_pkg::*;

  localparam int unsigned RandItems    = 400;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned SettleCycles = 4;

  // characters just outside or at the edges of the letter and digit ranges
  localparam char_t BorderChars [10] = '{
    16'h002f, 16'h003a, 16'h0040, 16'h005b, 16'h0060,
    16'h007b, 16'h005a, 16'h007a, 16'h0030, 16'h0039
  };
  // separators: space, dash, dot, underscore
  localparam char_t GapChars [4] = '{16'h0020, 16'h002d, 16'h002e, 16'h005f};

  typedef struct packed {
    logic found;
    pos_t pos;
  } search_result_t;

  typedef struct {
    bit                     is_cfg;
    logic [CfgIdxBits-1:0]  idx;
    logic [CfgDataBits-1:0] data;
    char_t                  ch;
    bit                     last;
    bit                     typed;
    search_result_t         want;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_index_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  ssww_in_if  text_if ();
  ssww_out_if res_if ();

  substring_search_whole_word dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (text_if),
    .out_if      (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // model copy of the registers
  logic [ModeBits-1:0]    cfg_mode;
  logic [LenBits-1:0]     cfg_len;
  pos_t                   cfg_start;
  logic [CfgDataBits-1:0] cfg_words [PatWords];

  // model copy of the search state
  char_t                 hist [WinDepth];
  logic [CountBits-1:0]  seen;
  logic                  hit;
  pos_t                  best;

  search_result_t awaited_results [$];
  plan_row_t      plan [$];
  char_t          pat_chars [MaxPattern];
  int             errors;
  int unsigned    rand_items;
  bit             calm;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 11);
  endfunction

  function automatic bit is_alnum(char_t c);
    return (c >= 16'h30 && c <= 16'h39) || (c >= 16'h41 && c <= 16'h5a) ||
           (c >= 16'h61 && c <= 16'h7a);
  endfunction

  function automatic char_t to_lower(char_t c);
    return (c >= 16'h41 && c <= 16'h5a) ? char_t'(c + 16'h20) : c;
  endfunction

  function automatic char_t pattern_char(int unsigned j);
    if (j >= MaxPattern) return '0;
    return cfg_words[j / CharsPerWord][CharBits * (j % CharsPerWord) +: CharBits];
  endfunction

  function automatic void clear_text();
    foreach (hist[k]) hist[k] = '0;
    seen = '0;
    hit  = 1'b0;
    best = '0;
  endfunction

  // one alignment of the pattern, first character at history slot top
  function automatic void try_alignment(int unsigned s, int unsigned used,
                                        int unsigned top, bit has_after);
    char_t t;
    char_t p;
    for (int unsigned j = 0; j < used; j++) begin
      t = hist[top - j];
      p = pattern_char(j);
      if (!cfg_mode[ModeMatchCase]) begin
        t = to_lower(t);
        p = to_lower(p);
      end
      if (t != p) return;
    end
    if (cfg_mode[ModeWholeWord]) begin
      if (s > 0 && top + 1 < WinDepth && is_alnum(hist[top + 1])) return;
      if (has_after && is_alnum(hist[top - used])) return;
    end
    if (cfg_mode[ModeReverse]) begin
      if (s + used <= cfg_start) begin
        hit  = 1'b1;
        best = pos_t'(s);
      end
    end else if (!hit && s >= cfg_start) begin
      hit  = 1'b1;
      best = pos_t'(s);
    end
  endfunction

  // advance the search by one character, returns 1 when a result is due
  function automatic bit predict_char(char_t c, bit last, output search_result_t r);
    int unsigned used;
    int unsigned n;
    used = (cfg_len > MaxPattern) ? MaxPattern : cfg_len;
    r = '0;
    for (int k = WinDepth - 1; k > 0; k--) hist[k] = hist[k - 1];
    hist[0] = c;
    if (!seen[PosBits] && used > 0) begin
      n = seen;
      if (n >= used) try_alignment(n - used, used, used, 1'b1);
      if (last && n + 1 >= used) try_alignment(n + 1 - used, used, used - 1, 1'b0);
    end
    if (!seen[PosBits]) seen++;
    if (!last) return 1'b0;
    r.found = hit;
    r.pos   = hit ? best : '0;
    clear_text();
    return 1'b1;
  endfunction

  function automatic char_t pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return char_t'(16'h61 + $urandom_range(3));
    if (r < 55) return char_t'(16'h41 + $urandom_range(3));
    if (r < 70) return GapChars[$urandom_range(3)];
    if (r < 78) return char_t'(16'h30 + $urandom_range(9));
    if (r < 88) return BorderChars[$urandom_range(9)];
    return char_t'($urandom);
  endfunction

  // plan building
  function automatic void add_cfg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    plan_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    plan.push_back(row);
  endfunction

  function automatic void add_char(char_t ch, bit last, bit typed, logic f, pos_t p);
    plan_row_t row;
    row           = '{default: '0};
    row.ch        = ch;
    row.last      = last;
    row.typed     = typed;
    row.want.found = f;
    row.want.pos   = p;
    plan.push_back(row);
  endfunction

  function automatic void add_text(string s, bit typed, logic f, pos_t p);
    for (int i = 0; i < s.len(); i++) add_char(char_t'(s[i]), i == s.len() - 1, typed, f, p);
  endfunction

  // one character beat, then maybe a gap
  task automatic send_char(char_t ch, bit last, bit typed, search_result_t want);
    search_result_t got;
    text_if.valid     <= 1'b1;
    text_if.text_char <= ch;
    text_if.last_char <= last;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    if (predict_char(ch, last, got)) awaited_results.push_back(typed ? want : got);
    while (take_break()) begin
      text_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // hold the sender until every result is back and the pipeline is empty
  task automatic settle();
    text_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegMode:     cfg_mode     = data[ModeBits-1:0];
      RegPatLen:   cfg_len      = data[LenBits-1:0];
      RegStartPos: cfg_start    = data[PosBits-1:0];
      RegPatWord0: cfg_words[0] = data;
      RegPatWord1: cfg_words[1] = data;
      RegPatWord2: cfg_words[2] = data;
      RegPatWord3: cfg_words[3] = data;
      default: ;
    endcase
  endtask

  // random setting, upper register bits filled with noise
  task automatic new_setting();
    logic [ModeBits-1:0]    mode;
    int unsigned            r;
    int unsigned            len;
    pos_t                   start;
    logic [CfgDataBits-1:0] word;
    settle();
    mode = ModeBits'($urandom_range(7));
    r = $urandom_range(99);
    if (r < 5)       len = 0;
    else if (r < 80) len = $urandom_range(1, 5);
    else if (r < 92) len = $urandom_range(6, MaxPattern);
    else             len = $urandom_range(MaxPattern + 1, 31);
    foreach (pat_chars[k]) pat_chars[k] = pick_char();
    r = $urandom_range(99);
    if (mode[ModeReverse]) start = (r < 15) ? '1 : pos_t'($urandom_range(30));
    else if (r < 50)       start = '0;
    else if (r < 95)       start = pos_t'($urandom_range(1, 20));
    else                   start = pos_t'($urandom);
    word = {$urandom, $urandom};
    word[ModeBits-1:0] = mode;
    write_reg(RegMode, word);
    word = {$urandom, $urandom};
    word[LenBits-1:0] = LenBits'(len);
    write_reg(RegPatLen, word);
    word = {$urandom, $urandom};
    word[PosBits-1:0] = start;
    write_reg(RegStartPos, word);
    for (int w = 0; w < PatWords; w++) begin
      for (int i = 0; i < CharsPerWord; i++)
        word[CharBits * i +: CharBits] = pat_chars[w * CharsPerWord + i];
      write_reg(CfgIdxBits'(RegPatWord0 + w), word);
    end
  endtask

  // random text with whole or cut pattern copies in mixed case
  task automatic send_text();
    int unsigned n;
    int unsigned used;
    int unsigned span;
    int unsigned at;
    char_t       ch;
    char_t       text_buf [$];
    n    = ($urandom_range(99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 40);
    used = (cfg_len > MaxPattern) ? MaxPattern : cfg_len;
    for (int i = 0; i < n; i++) text_buf.push_back(pick_char());
    repeat ($urandom_range(3)) begin
      if (used > 0 && used <= n) begin
        span = ($urandom_range(3) == 0) ? $urandom_range(1, used) : used;
        at   = $urandom_range(n - span);
        for (int j = 0; j < span; j++) begin
          ch = pat_chars[j];
          if ($urandom_range(1)) begin
            if (ch >= 16'h61 && ch <= 16'h7a)      ch = ch - 16'h20;
            else if (ch >= 16'h41 && ch <= 16'h5a) ch = ch + 16'h20;
          end
          text_buf[at + j] = ch;
        end
      end
    end
    for (int i = 0; i < n; i++) send_char(text_buf[i], i == n - 1, 1'b0, '0);
    rand_items += n;
  endtask

  // result sink ready
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= !take_break();
    end
  end

  // result checker
  always @(posedge clk_i) begin
    search_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result beat: found %0d, match_position %0d",
               res_if.found, res_if.match_position);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (res_if.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, res_if.found);
          errors++;
        end
        if (res_if.match_position !== want.pos) begin
          $error("match_position: expected %0d, got %0d", want.pos, res_if.match_position);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((text_if.valid && text_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus
  initial begin
    errors            = 0;
    rand_items        = 0;
    calm              = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    text_if.valid     = 1'b0;
    text_if.text_char = '0;
    text_if.last_char = 1'b0;
    cfg_mode          = '0;
    cfg_len           = LenBits'(1);
    cfg_start         = '0;
    foreach (cfg_words[w]) cfg_words[w] = '0;
    clear_text();

    // reset pattern is one zero character, case-insensitive, forward
    add_char(16'h0000, 1'b1, 1'b1, 1'b1, '0);
    add_char(16'hffff, 1'b1, 1'b1, 1'b0, '0);
    // exact, whole word, reverse from the far end: pattern "abc"
    add_cfg(RegMode, 64'(3'b111));
    add_cfg(RegPatLen, 64'd3);
    add_cfg(RegStartPos, 64'hf_ffff);
    add_cfg(RegPatWord0, 64'hffff_0063_0062_0061);
    add_cfg(RegPatWord1, '1);
    add_cfg(RegPatWord2, '1);
    add_cfg(RegPatWord3, '1);
    add_text("abc abc", 1'b1, 1'b1, 20'd4);
    add_text("xabc", 1'b1, 1'b0, '0);
    add_text("ABC", 1'b1, 1'b0, '0);
    // zero pattern length never matches
    add_cfg(RegMode, '0);
    add_cfg(RegPatLen, '0);
    add_text("a", 1'b1, 1'b0, '0);
    // oversized length saturates, pattern longer than the text
    add_cfg(RegPatLen, 64'd31);
    add_text("ab", 1'b1, 1'b0, '0);
    // case folding on both sides, forward from zero
    add_cfg(RegPatLen, 64'd2);
    add_cfg(RegStartPos, '0);
    add_cfg(RegPatWord0, 64'h0042_0061);
    add_text("AbAb", 1'b0, 1'b0, '0);
    // forward start past the end of the text
    add_cfg(RegStartPos, 64'd10);
    add_text("ab", 1'b1, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed plan
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_char(plan[i].ch, plan[i].last, plan[i].typed, plan[i].want);
      end
    end

    // random settings and texts, with a stretch of back-to-back traffic
    while (rand_items < RandItems) begin
      calm = (rand_items >= 150 && rand_items < 260);
      new_setting();
      repeat ($urandom_range(2, 5)) send_text();
    end
    calm = 1'b0;

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ssww_pkg.sv
rtl/ssww_if.sv
rtl/ssww_cand.sv
rtl/substring_search_whole_word.sv
sim/tb_top.sv
